/* rtl/core/ipfdf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the CRC-32 byte step of the IPF block deframer.
package ipfdf_pkg;

    // CRC-32, MSB first, no reflection, no final xor
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // header layout: type word, length word, CRC word
    localparam logic [3:0] HDR_BYTES    = 4'd12;
    localparam logic [3:0] HDR_TYPE_END = 4'd4;
    localparam logic [3:0] HDR_LEN_END  = 4'd8;

    localparam logic [31:0] TYPE_CAPS    = 32'd1;
    localparam logic [31:0] TYPE_IMGE    = 32'd3;
    localparam logic [31:0] TYPE_END     = 32'd10;
    localparam logic [31:0] DESC_MIN_LEN = 32'd80;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOT_IPF = 2'd1;
    localparam logic [1:0] STATUS_TRUNC   = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  cylinder;
        logic [1:0]  head;
        logic [7:0]  encoding;
        logic [23:0] start_pos;
        logic [23:0] bit_len;
        logic [2:0]  trk_attr;
    } t_desc_fields;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_type;
        logic [31:0] block_length;
        logic        crc_ok;
        logic        descriptor_valid;
        logic [7:0]  cylinder;
        logic [1:0]  head;
        logic [7:0]  encoding;
        logic [23:0] start_pos;
        logic [23:0] bit_len;
        logic [2:0]  trk_attr;
        logic        stream_done;
    } t_out_item;

    // one payload byte through the CRC register
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h00_0000};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/core/ipf_block_deframer_crc_check_unit.sv */
`timescale 1ns / 1ps
// Top level of the IPF block deframer with payload CRC-32 check.
//
// Usage:
//  - Byte channel (i_in_valid / i_in_data / o_in_stall): one byte of the image
//    file per transfer; last_byte marks the final byte of a file.
//  - Result channel (o_out_valid / o_out_data / i_out_stall): at most one result
//    per byte, issued when a block completes, the stream is rejected or cut short.
//  - Throughput: one byte per cycle while o_in_stall is low. The CRC byte step, header assembly and
//    descriptor capture all sit in one register-to-register stage.
//  - A result is registered from the byte that caused it (in the skid slot under a stall).
//  - Receiver stall: the result register holds; one further result fits in the
//    skid slot, and only once that slot is occupied is o_in_stall raised
//    (registered, so it never depends combinationally on i_out_stall).
//  - Reset (synchronous, active low): parser returns to header phase, expecting
//    a CAPS block first; both result slots are emptied. No clearing pass.
//  - After an end block or reject, bytes are swallowed without a result until
//    last_byte; truncation only comes on one. Any last_byte rearms for a new file.
module ipf_block_deframer_crc_check_unit import ipfdf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic      in_transfer;
    logic      res_valid;
    t_out_item res_data;
    logic      buf_full;

    // stall is purely the skid slot being occupied
    assign o_in_stall  = buf_full;
    assign in_transfer = i_in_valid && !buf_full;

    ipfdf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_transfer),
        .i_item      (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res_data)
    );

    ipfdf_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_data (res_data),
        .o_full      (buf_full),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data),
        .i_stall     (i_out_stall)
    );

endmodule

/* rtl/core/ipfdf_parser.sv */
`timescale 1ns / 1ps
// Block parser: header assembly, payload CRC, descriptor capture and result forming.
module ipfdf_parser import ipfdf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_res
);

    // descriptor word indices within the payload
    localparam logic [29:0] WORD_CYL   = 30'd0;
    localparam logic [29:0] WORD_HEAD  = 30'd1;
    localparam logic [29:0] WORD_ENC   = 30'd3;
    localparam logic [29:0] WORD_SBIT  = 30'd6;
    localparam logic [29:0] WORD_TBITS = 30'd9;
    localparam logic [29:0] WORD_FLAGS = 30'd12;

    t_phase       r_phase, n_phase;
    logic         r_first, n_first;
    logic [3:0]   r_hdr_cnt, n_hdr_cnt;
    logic [31:0]  r_type, n_type;
    logic [31:0]  r_len, n_len;
    logic [31:0]  r_exp_crc, n_exp_crc;
    logic [31:0]  r_crc, n_crc;
    logic [31:0]  r_offset, n_offset;
    logic [23:0]  r_wsh, n_wsh;
    t_desc_fields r_fields, n_fields;

    logic [7:0]   b;
    logic         last;
    logic         in_hdr, in_pay;
    logic [3:0]   hdr_idx, hdr_inc;
    logic         hdr_full;
    logic [31:0]  type_new, len_new, exp_new;
    logic [31:0]  crc_new, off_inc, word;
    t_desc_fields fields_new;
    logic         reject, hdr_end, hdr_fin, hdr_trunc, hdr_cut;
    logic         pay_end, pay_fin, pay_cut, finish, stop, go_done, abort, desc;

    assign b      = i_item.byte_value;
    assign last   = i_item.last_byte;
    assign in_hdr = (r_phase == PH_HEADER);
    assign in_pay = (r_phase == PH_PAYLOAD);

    // header assembly
    assign hdr_idx  = (r_hdr_cnt >= HDR_BYTES) ? (HDR_BYTES - 4'd1) : r_hdr_cnt;
    assign hdr_inc  = hdr_idx + 4'd1;
    assign hdr_full = (hdr_inc == HDR_BYTES);
    assign type_new = (in_hdr && hdr_idx < HDR_TYPE_END) ? {r_type[23:0], b} : r_type;
    assign len_new  = (in_hdr && hdr_idx >= HDR_TYPE_END && hdr_idx < HDR_LEN_END)
                      ? {r_len[23:0], b} : r_len;
    assign exp_new  = (in_hdr && hdr_idx >= HDR_LEN_END) ? {r_exp_crc[23:0], b} : r_exp_crc;

    // payload datapath
    assign crc_new = crc32_byte(r_crc, b);
    assign off_inc = r_offset + 32'd1;
    assign word    = {r_wsh, b};

    always_comb begin
        fields_new = r_fields;
        if (r_offset[1:0] == 2'b11) begin
            if (r_offset[31:2] == WORD_CYL)
                fields_new.cylinder = (|word[31:8]) ? 8'hFF : word[7:0];
            if (r_offset[31:2] == WORD_HEAD)
                fields_new.head = (|word[31:2]) ? 2'h3 : word[1:0];
            if (r_offset[31:2] == WORD_ENC)
                fields_new.encoding = (|word[31:8]) ? 8'hFF : word[7:0];
            if (r_offset[31:2] == WORD_SBIT)
                fields_new.start_pos = (|word[31:24]) ? 24'hFF_FFFF : word[23:0];
            if (r_offset[31:2] == WORD_TBITS)
                fields_new.bit_len = (|word[31:24]) ? 24'hFF_FFFF : word[23:0];
            if (r_offset[31:2] == WORD_FLAGS)
                fields_new.trk_attr = word[2:0];
        end
    end

    // events of this byte
    assign reject    = in_hdr && r_first && (hdr_inc == HDR_TYPE_END) && (type_new != TYPE_CAPS);
    assign hdr_end   = in_hdr && !reject && hdr_full;
    assign hdr_fin   = hdr_end && (len_new == 32'd0);
    assign hdr_trunc = hdr_end && (len_new != 32'd0) && last;
    assign hdr_cut   = in_hdr && !reject && !hdr_full && last;
    assign pay_end   = (off_inc == r_len);
    assign pay_fin   = in_pay && pay_end;
    assign pay_cut   = in_pay && !pay_end && last;
    assign finish    = hdr_fin || pay_fin;
    assign stop      = finish && ((type_new == TYPE_END) || last);
    assign go_done   = !last && (reject || stop);
    assign abort     = reject || hdr_trunc || hdr_cut || pay_cut;
    assign desc      = pay_fin && (r_type == TYPE_IMGE) && (r_len >= DESC_MIN_LEN);

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_first   = r_first;
        n_hdr_cnt = r_hdr_cnt;
        n_type    = r_type;
        n_len     = r_len;
        n_exp_crc = r_exp_crc;
        n_crc     = r_crc;
        n_offset  = r_offset;
        n_wsh     = r_wsh;
        n_fields  = r_fields;
        if (i_accept) begin
            if (in_hdr) begin
                n_type    = type_new;
                n_len     = len_new;
                n_exp_crc = exp_new;
                n_hdr_cnt = hdr_full ? 4'd0 : hdr_inc;
            end
            if (hdr_end) begin
                n_first  = 1'b0;
                n_crc    = CRC_INIT;
                n_offset = 32'd0;
                n_fields = '0;
                n_phase  = (len_new != 32'd0) ? PH_PAYLOAD : PH_HEADER;
            end
            if (in_pay) begin
                n_crc    = crc_new;
                n_wsh    = word[23:0];
                n_fields = fields_new;
                n_offset = off_inc;
                if (pay_end)
                    n_phase = PH_HEADER;
            end
            if (go_done)
                n_phase = PH_DONE;
            // any final byte rearms for the next stream
            if (last) begin
                n_phase   = PH_HEADER;
                n_first   = 1'b1;
                n_hdr_cnt = 4'd0;
            end
        end
    end

    // result
    always_comb begin
        o_res_valid = i_accept && (abort || finish);
        o_res       = '0;
        if (finish) begin
            o_res.status           = STATUS_OK;
            o_res.block_type       = type_new;
            o_res.block_length     = len_new;
            o_res.crc_ok           = hdr_fin ? (exp_new == CRC_INIT) : (crc_new == r_exp_crc);
            o_res.descriptor_valid = desc;
            if (desc) begin
                o_res.cylinder  = fields_new.cylinder;
                o_res.head      = fields_new.head;
                o_res.encoding  = fields_new.encoding;
                o_res.start_pos = fields_new.start_pos;
                o_res.bit_len   = fields_new.bit_len;
                o_res.trk_attr  = fields_new.trk_attr;
            end
            o_res.stream_done = stop;
        end else if (abort) begin
            o_res.stream_done = 1'b1;
            if (reject) begin
                o_res.status     = STATUS_NOT_IPF;
                o_res.block_type = type_new;
            end else if (hdr_cut) begin
                o_res.status       = r_first ? STATUS_NOT_IPF : STATUS_TRUNC;
                o_res.block_type   = (hdr_inc >= HDR_TYPE_END) ? type_new : 32'd0;
                o_res.block_length = (hdr_inc >= HDR_LEN_END) ? len_new : 32'd0;
            end else begin
                o_res.status       = STATUS_TRUNC;
                o_res.block_type   = type_new;
                o_res.block_length = len_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_first   <= 1'b1;
            r_hdr_cnt <= 4'd0;
        end else begin
            r_phase   <= n_phase;
            r_first   <= n_first;
            r_hdr_cnt <= n_hdr_cnt;
        end
    end

    // datapath words are rebuilt before use, no reset needed
    always_ff @(posedge i_clk) begin
        r_type    <= n_type;
        r_len     <= n_len;
        r_exp_crc <= n_exp_crc;
        r_crc     <= n_crc;
        r_offset  <= n_offset;
        r_wsh     <= n_wsh;
        r_fields  <= n_fields;
    end

endmodule

/* rtl/core/ipfdf_out_buf.sv */
`timescale 1ns / 1ps
// Result register with skid slot; registered stall towards the byte side.
module ipfdf_out_buf import ipfdf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_push_data,
    output logic      o_full,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    logic      r_out_valid, r_skid_valid;
    t_out_item r_out, r_skid;
    logic      slot_free;

    assign slot_free = !r_out_valid || !i_stall;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign o_full    = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (slot_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_skid_valid)
                r_out <= r_skid;
            else if (i_push)
                r_out <= i_push_data;
        end else if (i_push) begin
            r_skid <= i_push_data;
        end
    end

endmodule

/* rtl/core/ipfdf_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the IPF block deframer, bound to the top level.
module ipfdf_checker import ipfdf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_item  i_in_data,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    // a held result keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // any non-ok status ends the stream
    a_abort_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != STATUS_OK) |-> o_out_data.stream_done)
        else $error("abort result without stream_done");

    // descriptor only for a long enough track block that parsed cleanly
    a_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.descriptor_valid |->
            (o_out_data.status == STATUS_OK) && (o_out_data.block_type == TYPE_IMGE)
            && (o_out_data.block_length >= DESC_MIN_LEN))
        else $error("descriptor on wrong block");

    // byte side only stalls after the result side held a result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> $past(o_out_valid && i_out_stall))
        else $error("input stall without output back-pressure");

endmodule

bind ipf_block_deframer_crc_check_unit ipfdf_checker u_ipfdf_checker (.*);
